### rtl/lpmd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lpmd_pkg;

  // Header length in bytes; the header bytes themselves are listed in header_char.
  localparam int unsigned HeaderLen = 15;
  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharNine = 8'h39;

  // Deframer phase, one-hot.
  typedef enum logic [2:0] {
    PH_HUNT = 3'b001,
    PH_LEN  = 3'b010,
    PH_DATA = 3'b100
  } phase_t;

  // One result item as it leaves the block.
  typedef struct packed {
    logic [31:0] msg_length;
    logic        last_of_message;
    logic [7:0]  payload_byte;
  } result_t;

  // Header byte expected at a given match position.
  function automatic logic [7:0] header_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = 8'h6D; // m
      4'd1:    c = 8'h65; // e
      4'd2:    c = 8'h73; // s
      4'd3:    c = 8'h73; // s
      4'd4:    c = 8'h61; // a
      4'd5:    c = 8'h67; // g
      4'd6:    c = 8'h65; // e
      4'd7:    c = 8'h5F; // _
      4'd8:    c = 8'h6C; // l
      4'd9:    c = 8'h65; // e
      4'd10:   c = 8'h6E; // n
      4'd11:   c = 8'h67; // g
      4'd12:   c = 8'h74; // t
      4'd13:   c = 8'h68; // h
      4'd14:   c = 8'h3A; // :
      default: c = 8'h6D;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/length_prefixed_message_deframer_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Length-prefixed message deframer. Takes a byte stream, one item per byte,
// drops everything until the 15-byte header text (the word message, an
// underscore, the word length and a colon), then reads a decimal
// length up to a colon and passes that many following bytes out, with tlast
// on the final byte and the declared length (low 32 bits) beside each one.
// A zero or empty length yields no message; any other character among the
// digits drops back to hunting; a length that overflows LENGTH_BITS
// saturates at its maximum. Rate: one item per cycle while the master side
// keeps up; each accepted payload byte's result is registered. The whole
// parse step is a single registered update of the phase, match position,
// length and remaining-count registers; a two-entry output stage absorbs a
// one-item stall on the master side before s_tready drops.
module length_prefixed_message_deframer_unit #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Slave side. s_tdata: [7:0] in_byte
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,
  // Master side. m_tdata: [7:0] payload_byte, [39:8] msg_length.
  // m_tlast: last_of_message.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,
  output logic             m_tlast
);

  localparam logic [LENGTH_BITS-1:0] LengthMax = '1;

  lpmd_pkg::phase_t       phase, phase_next;
  logic [3:0]             match_position, match_position_next;
  logic [LENGTH_BITS-1:0] length_accumulator, length_accumulator_next;
  logic [LENGTH_BITS-1:0] bytes_remaining, bytes_remaining_next;

  logic                   s_accept;
  logic                   numeral_in;
  logic [3:0]             digit;
  logic [LENGTH_BITS+3:0] length_scaled;
  logic                   is_last;
  lpmd_pkg::result_t      result;
  lpmd_pkg::result_t      out_item;

  assign s_accept = s_tvalid && s_tready;

  // Decimal step: acc * 10 + d as shift-adds, saturating when it exceeds
  // the length range.
  assign numeral_in = (s_tdata >= lpmd_pkg::CharZero) && (s_tdata <= lpmd_pkg::CharNine);
  assign digit      = 4'(s_tdata - lpmd_pkg::CharZero);
  assign length_scaled = (LENGTH_BITS+4)'({length_accumulator, 3'b000})
                       + (LENGTH_BITS+4)'({length_accumulator, 1'b0})
                       + (LENGTH_BITS+4)'(digit);

  assign is_last = (bytes_remaining <= LENGTH_BITS'(1));

  always_comb begin
    phase_next              = phase;
    match_position_next     = match_position;
    length_accumulator_next = length_accumulator;
    bytes_remaining_next    = bytes_remaining;
    case (phase)
      lpmd_pkg::PH_LEN: begin
        if (numeral_in) begin
          if (length_scaled > (LENGTH_BITS+4)'(LengthMax)) begin
            length_accumulator_next = LengthMax;
          end else begin
            length_accumulator_next = length_scaled[LENGTH_BITS-1:0];
          end
        end else if (s_tdata == lpmd_pkg::CharColon) begin
          // Nonzero length opens the payload; an empty or zero one is skipped.
          if (length_accumulator != '0) begin
            bytes_remaining_next = length_accumulator;
            phase_next           = lpmd_pkg::PH_DATA;
          end else begin
            phase_next = lpmd_pkg::PH_HUNT;
          end
          match_position_next = 4'd0;
        end else begin
          // Protocol error: drop the byte and go back to hunting.
          phase_next              = lpmd_pkg::PH_HUNT;
          match_position_next     = 4'd0;
          length_accumulator_next = '0;
        end
      end
      lpmd_pkg::PH_DATA: begin
        if (is_last) begin
          bytes_remaining_next = '0;
          phase_next           = lpmd_pkg::PH_HUNT;
          match_position_next  = 4'd0;
        end else begin
          bytes_remaining_next = bytes_remaining - LENGTH_BITS'(1);
        end
      end
      default: begin
        // Hunt for the header; a mismatching 'm' restarts at position one.
        phase_next = lpmd_pkg::PH_HUNT;
        if (s_tdata == lpmd_pkg::header_char(match_position)) begin
          if (match_position == 4'(lpmd_pkg::HeaderLen - 1)) begin
            phase_next              = lpmd_pkg::PH_LEN;
            match_position_next     = 4'd0;
            length_accumulator_next = '0;
          end else begin
            match_position_next = match_position + 4'd1;
          end
        end else begin
          match_position_next = (s_tdata == lpmd_pkg::header_char(4'd0)) ? 4'd1 : 4'd0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= lpmd_pkg::PH_HUNT;
      match_position     <= 4'd0;
      length_accumulator <= '0;
      bytes_remaining    <= '0;
    end else if (s_accept) begin
      phase              <= phase_next;
      match_position     <= match_position_next;
      length_accumulator <= length_accumulator_next;
      bytes_remaining    <= bytes_remaining_next;
    end
  end

  // Result item for a payload byte; the length keeps its low 32 bits.
  always_comb begin
    result.payload_byte    = s_tdata;
    result.last_of_message = is_last;
    result.msg_length      = 32'(length_accumulator);
  end

  lpmd_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid && (phase == lpmd_pkg::PH_DATA)),
    .in_ready  (s_tready),
    .in_data   (result),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_item)
  );

  assign m_tdata = {out_item.msg_length, out_item.payload_byte};
  assign m_tlast = out_item.last_of_message;

`ifndef NO_ASSERTIONS
  // Payload phase always has at least one byte due.
  assert property (@(posedge clk) disable iff (rst)
    (phase == lpmd_pkg::PH_DATA) |-> (bytes_remaining != '0))
    else $error("payload phase with no bytes remaining");

  // Match position never reaches the full header length.
  assert property (@(posedge clk) disable iff (rst)
    match_position < 4'(lpmd_pkg::HeaderLen))
    else $error("match position out of range");

  // Final payload byte returns the block to hunting.
  assert property (@(posedge clk) disable iff (rst)
    (s_accept && (phase == lpmd_pkg::PH_DATA) && is_last) |=> (phase == lpmd_pkg::PH_HUNT))
    else $error("no return to hunting after last payload byte");
`endif

endmodule

`default_nettype wire

### rtl/lpmd_skid.sv
`timescale 1ns / 1ps
`default_nettype none

// Two-entry output stage: an output register plus a skid register, so the
// upstream side keeps moving for one item while the downstream side stalls.
module lpmd_skid (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire lpmd_pkg::result_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output lpmd_pkg::result_t     out_data
);

  logic              skid_valid;
  lpmd_pkg::result_t skid_data;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      // Output slot frees up: refill from skid first, else from input.
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      out_data <= skid_valid ? skid_data : in_data;
    end
    if (!(out_ready || !out_valid) && in_valid && !skid_valid) begin
      skid_data <= in_data;
    end
  end

endmodule

`default_nettype wire

### test/length_prefixed_message_deframer_unit_tb.sv
`timescale 1ns / 1ps

module length_prefixed_message_deframer_unit_tb;

  localparam logic [31:0] LENGTH_MAX = 32'hFFFF_FFFF;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] in_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;           // [7:0] payload_byte, [39:8] msg_length
  logic        m_tlast;           // last_of_message

  length_prefixed_message_deframer_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // Stream bytes waiting to be offered, and payload items due from the block.
  logic [7:0]        pending_bytes[$];
  lpmd_pkg::result_t expected_payload[$];

  // Pacing, set between phases.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_request = 1'b0;
  int unsigned hold_left;

  int unsigned error_count = 0;
  int unsigned bytes_accepted = 0;
  int unsigned payload_checked = 0;
  int unsigned messages_seen = 0;

  // Deframer state as predicted.
  lpmd_pkg::phase_t parse_phase = lpmd_pkg::PH_HUNT;
  int unsigned      header_match = 0;
  logic [31:0]      declared_length = '0;
  logic [31:0]      payload_left = '0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] header_byte(input int unsigned pos);
    return lpmd_pkg::header_char(4'(pos));
  endfunction

  // Advance the predicted parser by one accepted byte.
  function automatic void deframe_byte(input logic [7:0] b);
    logic [31:0]       digit;
    lpmd_pkg::result_t r;
    case (parse_phase)
      lpmd_pkg::PH_LEN: begin
        if (b >= lpmd_pkg::CharZero && b <= lpmd_pkg::CharNine) begin
          digit = 32'(b - lpmd_pkg::CharZero);
          if (declared_length > (LENGTH_MAX - digit) / 10)
            declared_length = LENGTH_MAX;
          else
            declared_length = declared_length * 10 + digit;
        end else if (b == lpmd_pkg::CharColon) begin
          if (declared_length != 0) begin
            payload_left = declared_length;
            parse_phase = lpmd_pkg::PH_DATA;
          end else begin
            parse_phase = lpmd_pkg::PH_HUNT;
          end
          header_match = 0;
        end else begin
          parse_phase = lpmd_pkg::PH_HUNT;
          header_match = 0;
          declared_length = '0;
        end
      end
      lpmd_pkg::PH_DATA: begin
        r.payload_byte = b;
        r.last_of_message = (payload_left <= 1);
        r.msg_length = declared_length;
        expected_payload.push_back(r);
        if (payload_left <= 1) begin
          payload_left = '0;
          parse_phase = lpmd_pkg::PH_HUNT;
          header_match = 0;
        end else begin
          payload_left = payload_left - 1;
        end
      end
      default: begin
        parse_phase = lpmd_pkg::PH_HUNT;
        if (b == header_byte(header_match)) begin
          header_match++;
          if (header_match == lpmd_pkg::HeaderLen) begin
            parse_phase = lpmd_pkg::PH_LEN;
            header_match = 0;
            declared_length = '0;
          end
        end else begin
          header_match = (b == header_byte(0)) ? 1 : 0;
        end
      end
    endcase
  endfunction

  // Sender: offer the next queued byte, idling at random.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= 8'h00;
    end else begin
      if (s_tvalid && s_tready) begin
        deframe_byte(s_tdata);
        bytes_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata <= pending_bytes.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long output hold-off, counted down on its own.
  always @(posedge clk) begin
    if (rst)
      hold_left <= 0;
    else if (hold_request)
      hold_left <= 300;
    else if (hold_left != 0)
      hold_left <= hold_left - 1;
  end

  // Receiver: stall at random, and hold fully during a hold-off.
  always @(posedge clk) begin
    if (rst)
      m_tready <= 1'b0;
    else
      m_tready <= (hold_left == 0) && !hold_request &&
                  ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each payload item with the oldest prediction.
  always @(posedge clk) begin
    lpmd_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_payload.size() == 0) begin
        $display("%0t: unexpected item data %h last %b", $time, m_tdata, m_tlast);
        error_count++;
      end else begin
        want = expected_payload.pop_front();
        payload_checked++;
        if (m_tlast) messages_seen++;
        if (m_tdata[7:0] !== want.payload_byte) begin
          $display("%0t: payload_byte expected %h got %h", $time,
                   want.payload_byte, m_tdata[7:0]);
          error_count++;
        end
        if (m_tlast !== want.last_of_message) begin
          $display("%0t: last_of_message expected %b got %b", $time,
                   want.last_of_message, m_tlast);
          error_count++;
        end
        if (m_tdata[39:8] !== want.msg_length) begin
          $display("%0t: msg_length expected %0d got %0d", $time,
                   want.msg_length, m_tdata[39:8]);
          error_count++;
        end
      end
    end
  end

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) pending_bytes.push_back(s[i]);
  endtask

  task automatic push_header();
    for (int i = 0; i < lpmd_pkg::HeaderLen; i++) pending_bytes.push_back(header_byte(i));
  endtask

  task automatic push_random(input int unsigned count);
    for (int i = 0; i < count; i++) pending_bytes.push_back(8'($urandom_range(255)));
  endtask

  function automatic logic [7:0] random_bad_char();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    while ((c >= lpmd_pkg::CharZero && c <= lpmd_pkg::CharNine) || c == lpmd_pkg::CharColon)
      c = 8'($urandom_range(255));
    return c;
  endfunction

  // Queue a complete message: header, decimal length, colon, payload.
  task automatic push_message(input int unsigned len, input int unsigned zeros);
    push_header();
    for (int i = 0; i < zeros; i++) push_text("0");
    push_text($sformatf("%0d:", len));
    push_random(len);
  endtask

  // Mostly well-formed messages with random content, the rest broken framing.
  task automatic push_random_stream(input int unsigned count);
    int unsigned start;
    int unsigned roll;
    int unsigned len;
    start = pending_bytes.size();
    while (pending_bytes.size() - start < count) begin
      roll = $urandom_range(99);
      if (roll < 70) begin
        push_random($urandom_range(3));
        len = ($urandom_range(99) < 85) ? $urandom_range(1, 12) : $urandom_range(13, 70);
        push_message(len, ($urandom_range(7) == 0) ? $urandom_range(1, 3) : 0);
      end else if (roll < 78) begin
        push_header();
        for (int i = $urandom_range(3); i > 0; i--) push_text("0");
        push_text(":");
      end else if (roll < 88) begin
        push_header();
        for (int i = $urandom_range(3); i > 0; i--)
          pending_bytes.push_back(8'(lpmd_pkg::CharZero + $urandom_range(9)));
        pending_bytes.push_back(random_bad_char());
      end else if (roll < 95) begin
        for (int i = $urandom_range(1, lpmd_pkg::HeaderLen - 1); i > 0; i--)
          pending_bytes.push_back(header_byte(lpmd_pkg::HeaderLen - 1 - i));
        push_random(1);
      end else begin
        push_random($urandom_range(1, 8));
      end
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_bytes.size() != 0 || s_tvalid || expected_payload.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed framing cases, no idling.
    push_text("xyz");
    push_header();
    push_text("1:");
    pending_bytes.push_back(8'h00);
    push_header();
    push_text("3:");
    pending_bytes.push_back(8'hFF);
    pending_bytes.push_back(8'h80);
    pending_bytes.push_back(8'h7F);
    // broken header restarts on the 'm' that broke it
    push_text("mess");
    push_header();
    push_text("2:");
    pending_bytes.push_back(8'h01);
    pending_bytes.push_back(8'hFE);
    // header cut off by a wrong last letter
    for (int i = 0; i < lpmd_pkg::HeaderLen - 2; i++) pending_bytes.push_back(header_byte(i));
    push_text("H");
    push_message(4, 0);
    // empty and zero lengths yield nothing
    push_header();
    push_text(":");
    push_header();
    push_text("000:");
    // bad character among digits, also after saturating
    push_header();
    push_text("12x");
    push_header();
    push_text("99999999999999z");
    push_message(7, 2);
    wait_drained();

    // Hold the output long enough for the block to stall its input.
    hold_request = 1'b1;
    @(negedge clk);
    hold_request = 1'b0;
    push_message(60, 0);
    wait_drained();

    // Random framing under each pacing mode.
    push_random_stream(120);
    wait_drained();
    send_idle_pct = 69;
    push_random_stream(120);
    wait_drained();
    send_idle_pct = 0;
    recv_stall_pct = 69;
    push_random_stream(120);
    wait_drained();
    send_idle_pct = 16;
    recv_stall_pct = 16;
    push_random_stream(120);
    wait_drained();

    // Saturated length last: the payload never ends, so check a few bytes.
    push_header();
    push_text("429496729600:");
    push_random(6);
    wait_drained();
    repeat (20) @(posedge clk);

    $display("Sent %0d stream bytes; checked %0d payload items in %0d complete messages,",
             bytes_accepted, payload_checked, messages_seen);
    $display("with broken headers, bad lengths, saturation, four pacing modes and a hold-off.");
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout waiting for the deframer");
    $display("Some tests failed");
    $finish;
  end

endmodule

### length_prefixed_message_deframer_unit.f
rtl/lpmd_pkg.sv
rtl/lpmd_skid.sv
rtl/length_prefixed_message_deframer_unit.sv
test/length_prefixed_message_deframer_unit_tb.sv
